>>> rtl/dense_layer_matvec_bias_unit_macros.svh
// assertion helpers, clocked on clock and held off while reset is high
`ifndef DENSE_LAYER_MATVEC_BIAS_UNIT_MACROS_SVH
`define DENSE_LAYER_MATVEC_BIAS_UNIT_MACROS_SVH

// same-cycle implication
`define DLMV_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLMV_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dlmv_pkg.sv
package dlmv_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int FIELD_BITS = 16;

   localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
   localparam logic [1:0] FUNC_BIAS    = 2'd1;
   localparam logic [1:0] FUNC_ELEMENT = 2'd2;

   localparam logic CSR_INPUTS  = 1'b0;
   localparam logic CSR_NEURONS = 1'b1;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } dlmv_mac_ctrl_type;

endpackage

>>> rtl/dlmv_mac.sv
module dlmv_mac import dlmv_pkg::*; #(
   parameter int EFF_BITS = 16,
   parameter int ACC_BITS = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dlmv_mac_ctrl_type          ctrl_in,
   input  logic signed [EFF_BITS-1:0] x_in,
   input  logic signed [EFF_BITS-1:0] w_in,
   input  logic signed [EFF_BITS-1:0] bias_in,
   output logic                       done,
   output logic signed [31:0]         sum,
   output logic                       sat
);

   localparam int PROD_BITS = 2 * EFF_BITS;

   dlmv_mac_ctrl_type            prod_ctrl_ff;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic signed [EFF_BITS-1:0]   bias_ff;
   logic signed [ACC_BITS-1:0]   acc_ff;
   logic signed [ACC_BITS-1:0]   acc_in;
   logic signed [ACC_BITS-1:0]   acc_base;
   logic                         done_ff;
   logic                         done_in;
   logic [ACC_BITS-32:0]         top_bits;

   assign prod_in = x_in * w_in;

   always_comb begin
      if (prod_ctrl_ff.first) begin
         acc_base = {{(ACC_BITS-EFF_BITS-FRAC_BITS){bias_ff[EFF_BITS-1]}}, bias_ff,
                     {FRAC_BITS{1'b0}}};
      end else begin
         acc_base = acc_ff;
      end
      acc_in  = acc_base + {{(ACC_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
      done_in = prod_ctrl_ff.valid && prod_ctrl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctrl_ff <= '0;
         done_ff      <= 1'b0;
      end else begin
         prod_ctrl_ff <= ctrl_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.valid) begin
         prod_ff <= prod_in;
      end
      if (ctrl_in.valid && ctrl_in.first) begin
         bias_ff <= bias_in;
      end
      if (prod_ctrl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // clip to signed 32 bits
   always_comb begin
      top_bits = acc_ff[ACC_BITS-1:31];
      sat      = !((&top_bits) || !(|top_bits));
      if (sat) begin
         sum = acc_ff[ACC_BITS-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sum = acc_ff[31:0];
      end
   end

   assign done = done_ff;

endmodule

>>> rtl/dense_layer_matvec_bias_unit.sv
// channel  dir  beat                                        handshake
// req      in   func, neuron_index, connection_index, value req_valid / req_ready
// rsp      out  neuron, weighted_sum, saturated, last       rsp_valid / rsp_ready
// csr      in   index, write data                           csr_write_enable, no wait
//
// weight, bias and non-final element beats are taken whenever req_ready is high and start no run
// the final element starts a run in which the one shared multiply-accumulate steps
// through the weight memory
// req_ready is low for the whole run; a stalled rsp holds the run at the next neuron
// reset is synchronous and clears control only; the stores hold no reset value
`include "dense_layer_matvec_bias_unit_macros.svh"

module dense_layer_matvec_bias_unit import dlmv_pkg::*; #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_NEURONS = 64,
   parameter int VALUE_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_neuron_index,
   input  logic [5:0]         req_connection_index,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_neuron,
   output logic signed [31:0] rsp_weighted_sum,
   output logic               rsp_saturated,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [6:0]         csr_write_data
);

   localparam int EFF_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam int ACC_BITS = (2 * EFF_BITS + 8 > 33) ? 2 * EFF_BITS + 8 : 33;
   localparam int W_DEPTH  = MAX_NEURONS * MAX_INPUTS;
   localparam int IN_AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int NEU_AW   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int CAP_IN   = (MAX_INPUTS < 127) ? MAX_INPUTS : 127;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [6:0]                 cfg_inputs_ff;
   logic [6:0]                 cfg_neurons_ff;
   logic [6:0]                 n_in_eff;
   logic [6:0]                 n_neu_eff;
   logic [6:0]                 j_ff, j_in;
   logic [NEU_AW-1:0]          n_ff, n_in;
   logic [W_AW-1:0]            rbase_ff, rbase_in;
   dlmv_mac_ctrl_type          iss_ctrl_ff, iss_ctrl_in;
   logic                       j_last;
   logic                       n_last;
   logic                       req_take;
   logic                       w_we, b_we, x_we;
   logic                       run_start;
   logic signed [EFF_BITS-1:0] val_eff;
   logic [W_AW-1:0]            w_waddr;
   logic [W_AW-1:0]            w_raddr;

   logic signed [EFF_BITS-1:0] weight_mem [W_DEPTH];
   logic signed [EFF_BITS-1:0] bias_mem [MAX_NEURONS];
   logic signed [EFF_BITS-1:0] input_mem [MAX_INPUTS];
   logic signed [EFF_BITS-1:0] w_rd_ff, b_rd_ff, x_rd_ff;

   logic                       mac_done;
   logic signed [31:0]         mac_sum;
   logic                       mac_sat;

   logic                       rsp_load;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [5:0]                 rsp_neuron_ff;
   logic signed [31:0]         rsp_sum_ff;
   logic                       rsp_sat_ff;
   logic                       rsp_last_ff, rsp_last_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_inputs_ff  <= 7'd64;
         cfg_neurons_ff <= 7'd64;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INPUTS:  cfg_inputs_ff  <= csr_write_data;
            CSR_NEURONS: cfg_neurons_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cfg_inputs_ff == 7'd0) begin
         n_in_eff = 7'd1;
      end else if (cfg_inputs_ff > 7'(CAP_IN)) begin
         n_in_eff = 7'(CAP_IN);
      end else begin
         n_in_eff = cfg_inputs_ff;
      end
      if (cfg_neurons_ff == 7'd0) begin
         n_neu_eff = 7'd1;
      end else if (cfg_neurons_ff > 7'(MAX_NEURONS)) begin
         n_neu_eff = 7'(MAX_NEURONS);
      end else begin
         n_neu_eff = cfg_neurons_ff;
      end
   end

   // request decode
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign val_eff   = req_value[EFF_BITS-1:0];

   always_comb begin
      w_we = 1'b0;
      b_we = 1'b0;
      x_we = 1'b0;
      unique case (req_func)
         FUNC_WEIGHT:  w_we = req_take && (32'(req_neuron_index) < MAX_NEURONS)
                              && (32'(req_connection_index) < MAX_INPUTS);
         FUNC_BIAS:    b_we = req_take && (32'(req_neuron_index) < MAX_NEURONS);
         FUNC_ELEMENT: x_we = req_take && (32'(req_connection_index) < MAX_INPUTS);
         default: ;
      endcase
      run_start = x_we && (7'(req_connection_index) == n_in_eff - 7'd1);
      w_waddr   = W_AW'(32'(req_neuron_index) * MAX_INPUTS + 32'(req_connection_index));
      w_raddr   = rbase_ff + W_AW'(j_ff);
   end

   // stores
   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= val_eff;
      end
      w_rd_ff <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_mem[NEU_AW'(req_neuron_index)] <= val_eff;
      end
      b_rd_ff <= bias_mem[n_ff];
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         input_mem[IN_AW'(req_connection_index)] <= val_eff;
      end
      x_rd_ff <= input_mem[IN_AW'(j_ff)];
   end

   // sequencer
   assign j_last   = (j_ff == n_in_eff - 7'd1);
   assign n_last   = (7'(n_ff) == n_neu_eff - 7'd1);
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      j_in        = j_ff;
      n_in        = n_ff;
      rbase_in    = rbase_ff;
      iss_ctrl_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (run_start) begin
               state_in = ST_ISSUE;
               j_in     = 7'd0;
               n_in     = '0;
               rbase_in = '0;
            end
         end
         ST_ISSUE: begin
            iss_ctrl_in = '{valid: 1'b1, first: (j_ff == 7'd0), last: j_last};
            if (j_last) begin
               state_in = ST_WAIT;
            end else begin
               j_in = j_ff + 7'd1;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (n_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  j_in     = 7'd0;
                  n_in     = n_ff + NEU_AW'(1);
                  rbase_in = rbase_ff + W_AW'(MAX_INPUTS);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         iss_ctrl_ff <= '0;
         j_ff        <= 7'd0;
         n_ff        <= '0;
         rbase_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         iss_ctrl_ff <= iss_ctrl_in;
         j_ff        <= j_in;
         n_ff        <= n_in;
         rbase_ff    <= rbase_in;
      end
   end

   dlmv_mac #(
      .EFF_BITS(EFF_BITS),
      .ACC_BITS(ACC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl_in (iss_ctrl_ff),
      .x_in    (x_rd_ff),
      .w_in    (w_rd_ff),
      .bias_in (b_rd_ff),
      .done    (mac_done),
      .sum     (mac_sum),
      .sat     (mac_sat)
   );

   // result register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_last_in  = n_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_neuron_ff <= 6'(n_ff);
         rsp_sum_ff    <= mac_sum;
         rsp_sat_ff    <= mac_sat;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_neuron       = rsp_neuron_ff;
   assign rsp_weighted_sum = rsp_sum_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last         = rsp_last_ff;

   `DLMV_ASSERT_IMP(a_done_only_in_wait, mac_done, state_ff == ST_WAIT, "mac finished outside wait")
   `DLMV_ASSERT_IMP(a_neuron_starts_clean, (state_ff == ST_ISSUE) && (j_ff == 7'd0), !iss_ctrl_ff.valid, "neuron issue overlaps previous")
   `DLMV_ASSERT_NXT(a_last_ends_run, rsp_load && rsp_last_in, state_ff == ST_IDLE, "run continued past last neuron")
   `DLMV_ASSERT_IMP(a_rsp_neuron_range, rsp_valid_ff, 7'(rsp_neuron_ff) < n_neu_eff, "result neuron out of range")

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import dlmv_pkg::*;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam int         MAX_CONNS     = 64;
   localparam int         MAX_CELLS     = 64;
   localparam int         RANDOM_BEATS  = 320;
   localparam int         SETTLE_CYCLES = 72;
   localparam int         DRAIN_CYCLES  = 80;
   localparam int         LONG_HOLD     = 400;
   localparam int         WATCHDOG_MAX  = 4000;
   localparam longint     SUM_MAX       = 64'sd2147483647;
   localparam longint     SUM_MIN       = -64'sd2147483648;

   typedef struct packed {
      logic [5:0]         neuron;
      logic signed [31:0] weighted_sum;
      logic               saturated;
      logic               last;
   } neuron_sum_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  neuron_index;
      logic [5:0]  connection_index;
      logic [15:0] value;
      logic        typed;
      logic [31:0] sum;
      logic        sat;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = FUNC_WEIGHT;
   logic [5:0]         req_neuron_index = '0;
   logic [5:0]         req_connection_index = '0;
   logic signed [15:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [5:0]         rsp_neuron;
   logic signed [31:0] rsp_weighted_sum;
   logic               rsp_saturated;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = CSR_INPUTS;
   logic [6:0]         csr_write_data = '0;

   // beat annotation for rows with a typed-in result
   logic               row_typed = 1'b0;
   logic [31:0]        row_sum = '0;
   logic               row_sat = 1'b0;

   // predictor state
   logic [6:0]         cfg_inputs = 7'd64;
   logic [6:0]         cfg_neurons = 7'd64;
   logic signed [15:0] weight_mem [0:4095];
   logic signed [15:0] bias_mem [0:63];
   logic signed [15:0] input_mem [0:63];
   neuron_sum_type     pending_sums [$];

   // sender-side bookkeeping of written entries
   bit                 w_written [0:4095];
   bit                 b_written [0:63];
   bit                 i_written [0:63];

   int                 fail_count = 0;
   int                 beats_sent = 0;
   int                 quiet_cycles = 0;
   bit                 idle_on = 1'b1;
   int                 hold_asked = 0;
   int                 hold_served = 0;
   int                 hold_left = 0;
   int                 burst_left = 0;

   stim_row_type       directed_rows [24];

   dense_layer_matvec_bias_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_neuron_index     (req_neuron_index),
      .req_connection_index (req_connection_index),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_neuron           (rsp_neuron),
      .rsp_weighted_sum     (rsp_weighted_sum),
      .rsp_saturated        (rsp_saturated),
      .rsp_last             (rsp_last),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp_count(input logic [6:0] reg_value, input int limit);
      if (reg_value == 7'd0) begin
         return 1;
      end
      return (int'(reg_value) > limit) ? limit : int'(reg_value);
   endfunction

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 255));
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic forward_layer(input logic [1:0] f, input logic [5:0] ni, input logic [5:0] ci,
                                input logic signed [15:0] v, input logic typed,
                                input logic [31:0] typed_sum, input logic typed_sat);
      int             n_in;
      int             n_neu;
      int             n;
      int             j;
      longint         acc;
      neuron_sum_type r;
      n_in  = clamp_count(cfg_inputs, MAX_CONNS);
      n_neu = clamp_count(cfg_neurons, MAX_CELLS);
      case (f)
         FUNC_WEIGHT: weight_mem[{ni, ci}] = v;
         FUNC_BIAS: bias_mem[ni] = v;
         FUNC_ELEMENT: begin
            input_mem[ci] = v;
            if (int'(ci) == n_in - 1) begin
               for (n = 0; n < n_neu; n++) begin
                  acc = longint'(bias_mem[n]) * 256;
                  for (j = 0; j < n_in; j++) begin
                     acc += longint'(input_mem[j]) * longint'(weight_mem[n * MAX_CONNS + j]);
                  end
                  r.neuron = 6'(n);
                  r.saturated = 1'b1;
                  if (acc > SUM_MAX) begin
                     r.weighted_sum = 32'h7FFF_FFFF;
                  end else if (acc < SUM_MIN) begin
                     r.weighted_sum = 32'h8000_0000;
                  end else begin
                     r.weighted_sum = acc[31:0];
                     r.saturated = 1'b0;
                  end
                  r.last = (n == n_neu - 1);
                  if (typed) begin
                     r.weighted_sum = typed_sum;
                     r.saturated = typed_sat;
                  end
                  pending_sums.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // predictor and scoreboard, sampled at the rising edge
   always @(posedge clock) begin
      neuron_sum_type want;
      if (!reset) begin
         if (csr_write_enable) begin
            if (csr_index == CSR_INPUTS) begin
               cfg_inputs = csr_write_data;
            end else begin
               cfg_neurons = csr_write_data;
            end
         end
         if (req_valid && req_ready) begin
            forward_layer(req_func, req_neuron_index, req_connection_index, req_value,
                          row_typed, row_sum, row_sat);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_sums.size() == 0) begin
               $error("rsp beat with nothing expected: neuron %0d sum %0d",
                      rsp_neuron, rsp_weighted_sum);
               fail_count++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp_neuron !== want.neuron) begin
                  $error("neuron: expected %0d, got %0d", want.neuron, rsp_neuron);
                  fail_count++;
               end
               if (rsp_weighted_sum !== want.weighted_sum) begin
                  $error("weighted_sum: expected %0d, got %0d",
                         want.weighted_sum, rsp_weighted_sum);
                  fail_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d", want.saturated, rsp_saturated);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         burst_left = $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         burst_left = $urandom_range(0, 30);
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(input logic [1:0] f, input logic [5:0] ni, input logic [5:0] ci,
                            input logic [15:0] v, input logic typed = 1'b0,
                            input logic [31:0] tsum = '0, input logic tsat = 1'b0);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_neuron_index <= ni;
      req_connection_index <= ci;
      req_value <= v;
      row_typed <= typed;
      row_sum <= tsum;
      row_sat <= tsat;
      case (f)
         FUNC_WEIGHT: w_written[{ni, ci}] = 1'b1;
         FUNC_BIAS: b_written[ni] = 1'b1;
         FUNC_ELEMENT: i_written[ci] = 1'b1;
         default: ;
      endcase
      if (f != FUNC_UNUSED) begin
         beats_sent++;
      end
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [6:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic set_layer_shape(input logic [6:0] in_reg, input logic [6:0] neu_reg);
      wait_idle();
      write_csr(CSR_INPUTS, in_reg);
      write_csr(CSR_NEURONS, neu_reg);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random loads and noise, then fill what the run reads, then the final element
   task automatic run_layer(input int n_in, input int n_neu);
      int n;
      int j;
      int c;
      repeat ($urandom_range(0, 8)) begin
         n = $urandom_range(0, n_neu - 1);
         j = $urandom_range(0, n_in - 1);
         c = $urandom_range(0, 63);
         if (c == n_in - 1) begin
            c = (c + 1) % MAX_CONNS;
         end
         case ($urandom_range(0, 5))
            0: send_beat(FUNC_WEIGHT, 6'(n), 6'(j), rand_value());
            1: send_beat(FUNC_BIAS, 6'(n), 6'($urandom_range(0, 63)), rand_value());
            2: send_beat(FUNC_ELEMENT, 6'($urandom_range(0, 63)), 6'(c), rand_value());
            3: send_beat(FUNC_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         16'($urandom));
            4: send_beat(FUNC_WEIGHT, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         rand_value());
            default: send_beat(FUNC_BIAS, 6'($urandom_range(0, 63)),
                               6'($urandom_range(0, 63)), rand_value());
         endcase
      end
      for (n = 0; n < n_neu; n++) begin
         if (!b_written[n]) begin
            send_beat(FUNC_BIAS, 6'(n), 6'($urandom_range(0, 63)), rand_value());
         end
         for (j = 0; j < n_in; j++) begin
            if (!w_written[n * MAX_CONNS + j]) begin
               send_beat(FUNC_WEIGHT, 6'(n), 6'(j), rand_value());
            end
         end
      end
      for (j = 0; j < n_in - 1; j++) begin
         if (!i_written[j]) begin
            send_beat(FUNC_ELEMENT, 6'($urandom_range(0, 63)), 6'(j), rand_value());
         end
      end
      send_beat(FUNC_ELEMENT, 6'($urandom_range(0, 63)), 6'(n_in - 1), rand_value());
   endtask

   initial begin
      logic [6:0] in_reg;
      logic [6:0] neu_reg;
      int         n_in;
      int         n_neu;
      int         phase;
      int         i;

      // two connections, one neuron
      directed_rows = '{
         '{FUNC_UNUSED,  6'd63, 6'd63, 16'hFFFF, 1'b0, 32'h0,         1'b0},
         '{FUNC_WEIGHT,  6'd0,  6'd0,  16'h8000, 1'b0, 32'h0,         1'b0},
         '{FUNC_WEIGHT,  6'd0,  6'd1,  16'h8000, 1'b0, 32'h0,         1'b0},
         '{FUNC_BIAS,    6'd0,  6'd0,  16'h0000, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd0,  16'h8000, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd1,  16'h8000, 1'b1, 32'h7FFF_FFFF, 1'b1},
         '{FUNC_WEIGHT,  6'd0,  6'd0,  16'h7FFF, 1'b0, 32'h0,         1'b0},
         '{FUNC_WEIGHT,  6'd0,  6'd1,  16'h7FFF, 1'b0, 32'h0,         1'b0},
         '{FUNC_BIAS,    6'd0,  6'd0,  16'h8000, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd1,  16'h8000, 1'b1, 32'h8000_0000, 1'b1},
         '{FUNC_WEIGHT,  6'd63, 6'd63, 16'h7FFF, 1'b0, 32'h0,         1'b0},
         '{FUNC_BIAS,    6'd63, 6'd0,  16'h8000, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd63, 16'h7FFF, 1'b0, 32'h0,         1'b0},
         '{FUNC_WEIGHT,  6'd0,  6'd0,  16'h0000, 1'b0, 32'h0,         1'b0},
         '{FUNC_WEIGHT,  6'd0,  6'd1,  16'h0000, 1'b0, 32'h0,         1'b0},
         '{FUNC_BIAS,    6'd0,  6'd0,  16'h7FFF, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd1,  16'h1234, 1'b1, 32'h007F_FF00, 1'b0},
         '{FUNC_BIAS,    6'd0,  6'd0,  16'h0100, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd1,  16'hFFFF, 1'b1, 32'h0001_0000, 1'b0},
         '{FUNC_WEIGHT,  6'd0,  6'd0,  16'h0100, 1'b0, 32'h0,         1'b0},
         '{FUNC_WEIGHT,  6'd0,  6'd1,  16'hFF00, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd0,  16'h0280, 1'b0, 32'h0,         1'b0},
         '{FUNC_ELEMENT, 6'd0,  6'd1,  16'h0180, 1'b0, 32'h0,         1'b0},
         '{FUNC_UNUSED,  6'd0,  6'd0,  16'h0000, 1'b0, 32'h0,         1'b0}
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      set_layer_shape(7'd2, 7'd1);
      for (i = 0; i < $size(directed_rows); i++) begin
         send_beat(directed_rows[i].func, directed_rows[i].neuron_index,
                   directed_rows[i].connection_index, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].sum, directed_rows[i].sat);
      end

      phase = 0;
      while (beats_sent < RANDOM_BEATS + $size(directed_rows) || phase < 3) begin
         case ($urandom_range(0, 14))
            0: begin
               in_reg = 7'd0;
               neu_reg = 7'($urandom_range(1, 4));
            end
            1: begin
               in_reg = 7'd64;
               neu_reg = 7'($urandom_range(1, 2));
            end
            2: begin
               in_reg = 7'($urandom_range(65, 127));
               neu_reg = 7'($urandom_range(0, 2));
            end
            3: begin
               in_reg = 7'($urandom_range(1, 2));
               neu_reg = 7'd64;
            end
            4: begin
               in_reg = 7'($urandom_range(0, 2));
               neu_reg = 7'($urandom_range(65, 127));
            end
            default: begin
               in_reg = 7'($urandom_range(1, 6));
               neu_reg = 7'($urandom_range(0, 6));
            end
         endcase
         if (phase == 2) begin
            in_reg = 7'd3;
            neu_reg = 7'd5;
         end
         set_layer_shape(in_reg, neu_reg);
         n_in = clamp_count(in_reg, MAX_CONNS);
         n_neu = clamp_count(neu_reg, MAX_CELLS);
         if (phase == 2) begin
            // long result stall while the sender keeps offering
            hold_asked++;
            run_layer(n_in, n_neu);
            run_layer(n_in, n_neu);
         end else begin
            repeat ($urandom_range(1, 3)) run_layer(n_in, n_neu);
         end
         phase++;
      end

      // last layer with no idling
      wait_idle();
      idle_on = 1'b0;
      set_layer_shape(7'd6, 7'd6);
      run_layer(6, 6);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/dlmv_pkg.sv
rtl/dlmv_mac.sv
rtl/dense_layer_matvec_bias_unit.sv
test/tb.sv
